### hdl/mcr_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
// Used by the controller, the datapath and the top level; no dependencies.
package mcr_pkg;

  // Result count cap per circle and its counter width
  localparam int MAX_RESULTS = 64;
  localparam int CNT_BITS    = $clog2(MAX_RESULTS);

  // Squared distance below this marks a center-only circle (radius below 3)
  localparam int SMALL_DSQ = 9;

  // Decision variable constants of the midpoint recurrence
  localparam int DEC_INIT = 3;
  localparam int DEC_DIAG = 10;
  localparam int DEC_AXIS = 6;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;      // latch input transaction
    logic square;       // square the axis distances
    logic sum;          // add the squares
    logic root_start;   // launch the square root unit
    logic init;         // load x, y, d from the radius
    logic load_step;    // register a result and advance one step
    logic load_single;  // register the center-only result
  } mcr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic center_only;  // squared distance below threshold
    logic root_done;    // square root result valid
    logic last;         // registered result is the final one
  } mcr_sts_t;

endpackage

### hdl/mcr_isqrt.sv
// Iterative integer square root (floor), one result bit per cycle.
// Standalone unit; no package dependency.
module mcr_isqrt #(
  parameter int W = 25
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] value_i,
  output logic [W-1:0] root_o,
  output logic         done_o
);

  localparam int ITER  = (W + 1) / 2;
  localparam int CNT_W = $clog2(ITER + 1);
  localparam logic [W-1:0] TOP_BIT = W'(1) << (2 * (ITER - 1));

  logic [W-1:0]     v_q, v_d;
  logic [W-1:0]     res_q, res_d;
  logic [W-1:0]     bit_q, bit_d;
  logic [W:0]       trial;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};

  // one bit pair per cycle
  always_comb begin
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      v_d    = value_i;
      res_d  = '0;
      bit_d  = TOP_BIT;
      cnt_d  = CNT_W'(ITER);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if ({1'b0, v_q} >= trial) begin
        v_d   = v_q - trial[W-1:0];
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign root_o = res_q;
  assign done_o = done_q;

endmodule

### hdl/mcr_ctrl.sv
// Controller state machine for the circle rasterizer.
// Depends on mcr_pkg for the command and status structs.
module mcr_ctrl
  import mcr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  mcr_sts_t sts_i,
  output mcr_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQUARE = 3'd1;
  localparam logic [2:0] S_SUM    = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_ROOT   = 3'd4;
  localparam logic [2:0] S_LOAD   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.center_only) begin
          cmd_o.load_single = 1'b1;
          state_d           = S_EMIT;
        end else begin
          cmd_o.root_start = 1'b1;
          state_d          = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sts_i.root_done) begin
          cmd_o.init = 1'b1;
          state_d    = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load_step = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        // advance while the taken result was not the final one
        if (!out_stall_i) begin
          if (sts_i.last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.load_step = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);

endmodule

### hdl/mcr_dp.sv
// Datapath: distance squaring, radius, midpoint recurrence, result register.
// Depends on mcr_pkg and instantiates mcr_isqrt.
module mcr_dp
  import mcr_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int RADIUS_MAX = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mcr_cmd_t                       cmd_i,
  output mcr_sts_t                       sts_o,
  input  logic        [COORD_BITS-1:0]   center_x_i,
  input  logic        [COORD_BITS-1:0]   center_y_i,
  input  logic        [COORD_BITS-1:0]   edge_x_i,
  input  logic        [COORD_BITS-1:0]   edge_y_i,
  output logic signed [COORD_BITS+1:0]   x_plus_a_o,
  output logic signed [COORD_BITS+1:0]   x_minus_a_o,
  output logic signed [COORD_BITS+1:0]   x_plus_b_o,
  output logic signed [COORD_BITS+1:0]   x_minus_b_o,
  output logic signed [COORD_BITS+1:0]   y_plus_a_o,
  output logic signed [COORD_BITS+1:0]   y_minus_a_o,
  output logic signed [COORD_BITS+1:0]   y_plus_b_o,
  output logic signed [COORD_BITS+1:0]   y_minus_b_o,
  output logic                           single_point_o,
  output logic                           clamped_o,
  output logic                           last_o
);

  localparam int OUT_BITS = COORD_BITS + 2;
  localparam int PR_BITS  = 2 * COORD_BITS;
  localparam int SQ_BITS  = 2 * COORD_BITS + 1;
  localparam int RAD_BITS = $clog2(RADIUS_MAX + 2);
  localparam int DEC_BITS = RAD_BITS + 5;

  // input transaction
  logic [COORD_BITS-1:0] cx_q, cy_q, ex_q, ey_q;
  // distances
  logic [COORD_BITS-1:0] adx, ady;
  logic [PR_BITS-1:0]    sqx_q, sqy_q, sqx_d, sqy_d;
  logic [SQ_BITS-1:0]    dsq_q;
  // radius
  logic [SQ_BITS-1:0]    root;
  logic                  root_done;
  logic                  over;
  logic [RAD_BITS-1:0]   rad;
  logic [DEC_BITS-1:0]   d_init;
  // recurrence
  logic [RAD_BITS-1:0]   x_q, y_q, x_nx, y_nx;
  logic [DEC_BITS-1:0]   d_q, d_nx, x_ext, y_ext;
  logic                  d_pos;
  logic [CNT_BITS-1:0]   n_q;
  logic                  clamp_q;
  logic                  last_nx;
  // result register
  logic [OUT_BITS-1:0]   cxe, cye, ae, be;
  logic [OUT_BITS-1:0]   xpa_q, xma_q, xpb_q, xmb_q, ypa_q, yma_q, ypb_q, ymb_q;
  logic                  single_q, clampo_q, last_q;

  // absolute axis distances
  assign adx = (cx_q >= ex_q) ? (cx_q - ex_q) : (ex_q - cx_q);
  assign ady = (cy_q >= ey_q) ? (cy_q - ey_q) : (ey_q - cy_q);
  assign sqx_d = PR_BITS'(adx) * PR_BITS'(adx);
  assign sqy_d = PR_BITS'(ady) * PR_BITS'(ady);

  mcr_isqrt #(
    .W (SQ_BITS)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.root_start),
    .value_i (dsq_q),
    .root_o  (root),
    .done_o  (root_done)
  );

  // clamp radius and seed the decision variable
  assign over   = root > SQ_BITS'(RADIUS_MAX);
  assign rad    = over ? RAD_BITS'(RADIUS_MAX) : root[RAD_BITS-1:0];
  assign d_init = DEC_BITS'(DEC_INIT) - (DEC_BITS'(rad) << 1);

  // one midpoint step
  assign d_pos = !d_q[DEC_BITS-1] && (d_q != '0);
  assign x_nx  = x_q + RAD_BITS'(1);
  assign y_nx  = d_pos ? (y_q - RAD_BITS'(1)) : y_q;
  assign x_ext = DEC_BITS'(x_nx);
  assign y_ext = DEC_BITS'(y_nx);
  assign d_nx  = d_pos ? (d_q + ((x_ext - y_ext) << 2) + DEC_BITS'(DEC_DIAG))
                       : (d_q + (x_ext << 2) + DEC_BITS'(DEC_AXIS));

  // final result when the octant is done or the cap is reached
  assign last_nx = (y_q < x_q) || (n_q == CNT_BITS'(MAX_RESULTS - 1));

  assign cxe = OUT_BITS'(cx_q);
  assign cye = OUT_BITS'(cy_q);
  assign ae  = OUT_BITS'(x_q);
  assign be  = OUT_BITS'(y_q);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      ex_q <= edge_x_i;
      ey_q <= edge_y_i;
    end
    if (cmd_i.square) begin
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
    end
    if (cmd_i.sum) begin
      dsq_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
    end
    if (cmd_i.init) begin
      x_q     <= '0;
      y_q     <= rad;
      d_q     <= d_init;
      n_q     <= '0;
      clamp_q <= over;
    end
    if (cmd_i.load_step) begin
      xpa_q    <= cxe + ae;
      xma_q    <= cxe - ae;
      xpb_q    <= cxe + be;
      xmb_q    <= cxe - be;
      ypa_q    <= cye + ae;
      yma_q    <= cye - ae;
      ypb_q    <= cye + be;
      ymb_q    <= cye - be;
      single_q <= 1'b0;
      clampo_q <= clamp_q;
      last_q   <= last_nx;
      x_q      <= x_nx;
      y_q      <= y_nx;
      d_q      <= d_nx;
      n_q      <= n_q + CNT_BITS'(1);
    end
    if (cmd_i.load_single) begin
      xpa_q    <= cxe;
      xma_q    <= cxe;
      xpb_q    <= cxe;
      xmb_q    <= cxe;
      ypa_q    <= cye;
      yma_q    <= cye;
      ypb_q    <= cye;
      ymb_q    <= cye;
      single_q <= 1'b1;
      clampo_q <= 1'b0;
      last_q   <= 1'b1;
    end
  end

  assign sts_o.center_only = dsq_q < SQ_BITS'(SMALL_DSQ);
  assign sts_o.root_done   = root_done;
  assign sts_o.last        = last_q;

  assign x_plus_a_o     = $signed(xpa_q);
  assign x_minus_a_o    = $signed(xma_q);
  assign x_plus_b_o     = $signed(xpb_q);
  assign x_minus_b_o    = $signed(xmb_q);
  assign y_plus_a_o     = $signed(ypa_q);
  assign y_minus_a_o    = $signed(yma_q);
  assign y_plus_b_o     = $signed(ypb_q);
  assign y_minus_b_o    = $signed(ymb_q);
  assign single_point_o = single_q;
  assign clamped_o      = clampo_q;
  assign last_o         = last_q;

endmodule

### hdl/midpoint_circle_rasterizer_top.sv
// Midpoint circle rasterizer. One transaction (center and edge point) is taken
// while the block is idle. Setup captures the transaction, squares the axis
// distances, sums them and checks for a small radius; then the square root
// unit runs, the recurrence is seeded and the first plot is registered.
// After that one result of eight mirrored points leaves per cycle while the
// output is not stalled; a circle of radius r gives about r/1.41 + 2 results,
// at most 64. A center-only circle skips the square root and the recurrence
// and registers its single result at the small-radius check. The next
// transaction is taken the cycle after the last result is taken.
// Depends on mcr_pkg, mcr_ctrl, mcr_dp and mcr_isqrt.
module midpoint_circle_rasterizer_top
  import mcr_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int RADIUS_MAX = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic        [COORD_BITS-1:0] center_x_i,
  input  logic        [COORD_BITS-1:0] center_y_i,
  input  logic        [COORD_BITS-1:0] edge_x_i,
  input  logic        [COORD_BITS-1:0] edge_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS+1:0] x_plus_a_o,
  output logic signed [COORD_BITS+1:0] x_minus_a_o,
  output logic signed [COORD_BITS+1:0] x_plus_b_o,
  output logic signed [COORD_BITS+1:0] x_minus_b_o,
  output logic signed [COORD_BITS+1:0] y_plus_a_o,
  output logic signed [COORD_BITS+1:0] y_minus_a_o,
  output logic signed [COORD_BITS+1:0] y_plus_b_o,
  output logic signed [COORD_BITS+1:0] y_minus_b_o,
  output logic                         single_point_o,
  output logic                         clamped_o,
  output logic                         last_o
);

  mcr_cmd_t cmd;
  mcr_sts_t sts;

  mcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mcr_dp #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_MAX (RADIUS_MAX)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .edge_x_i       (edge_x_i),
    .edge_y_i       (edge_y_i),
    .x_plus_a_o     (x_plus_a_o),
    .x_minus_a_o    (x_minus_a_o),
    .x_plus_b_o     (x_plus_b_o),
    .x_minus_b_o    (x_minus_b_o),
    .y_plus_a_o     (y_plus_a_o),
    .y_minus_a_o    (y_minus_a_o),
    .y_plus_b_o     (y_plus_b_o),
    .y_minus_b_o    (y_minus_b_o),
    .single_point_o (single_point_o),
    .clamped_o      (clamped_o),
    .last_o         (last_o)
  );

endmodule
